@@ hdl/mked_pkg.sv @@
// Package for the multi-key edge debouncer: widths, reset values,
// register codes and the per-lane configuration struct.
// No dependencies.
`timescale 1ns / 1ps

package mked_pkg;

  localparam int KEYS        = 5;   // number of key lanes, 1..8
  localparam int FIELD_W     = 5;   // width of the per-key bit fields
  localparam int WIN_W       = 16;
  localparam int TIME_W      = 32;
  localparam int IN_TDATA_W  = ((2 * FIELD_W + TIME_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((FIELD_W + 7) / 8) * 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [FIELD_W-1:0] EDGE_SRC_RST = 5'h1f;
  localparam logic [WIN_W-1:0]   WINDOW_RST   = 16'd20;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EDGE_SRC = 2'd0,
    REG_WINDOW   = 2'd1
  } mked_reg_t;

  // Configuration seen by one lane.
  typedef struct packed {
    logic             edge_src;
    logic [WIN_W-1:0] window;
  } mked_lane_cfg_t;

endpackage

@@ hdl/multi_key_edge_debouncer_top.sv @@
// Multi-key edge debouncer, top level. Each poll item carries pressed levels,
// captured falling edges and a millisecond timestamp; one result item with a
// debounced event bit per key comes back for every poll. The block takes one
// poll per clock cycle while in_tready is high, and each result is held in a
// register: per-key work is one 32-bit subtract and compare in each
// lane, all lanes side by side. A two-entry output buffer (register plus skid)
// lets polls keep flowing while a result waits; in_tready drops only when
// both entries are full. Configuration writes are always taken (cfg_ready is
// high) and should be made while no poll is in flight. Unknown register
// indexes are ignored. Depends on mked_pkg, mked_lane and mked_merge.
`timescale 1ns / 1ps

module multi_key_edge_debouncer_top (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata: [4:0] pressed_levels, [9:5] captured_edges, [41:10] time_now,
  // [47:42] zero
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [mked_pkg::IN_TDATA_W-1:0]     in_tdata,
  // out_tdata: [4:0] key_events, [7:5] zero
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [mked_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // register write: index 0 edge_source_mask, index 1 debounce_window
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mked_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mked_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [mked_pkg::FIELD_W-1:0] edge_src_r, edge_src_nxt;
  logic [mked_pkg::WIN_W-1:0]   window_r, window_nxt;
  logic [mked_pkg::FIELD_W-1:0] levels;
  logic [mked_pkg::FIELD_W-1:0] edges;
  logic [mked_pkg::TIME_W-1:0]  now;
  logic                         accept;
  logic [mked_pkg::KEYS-1:0]    fire;

  assign cfg_ready = 1'b1;

  // register file
  always_comb begin
    edge_src_nxt = edge_src_r;
    window_nxt   = window_r;
    if (cfg_valid && cfg_ready) begin
      unique case (mked_pkg::mked_reg_t'(cfg_index))
        mked_pkg::REG_EDGE_SRC: edge_src_nxt = cfg_data[mked_pkg::FIELD_W-1:0];
        mked_pkg::REG_WINDOW:   window_nxt   = cfg_data[mked_pkg::WIN_W-1:0];
        default: ;  // write ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_src_r <= mked_pkg::EDGE_SRC_RST;
      window_r   <= mked_pkg::WINDOW_RST;
    end else begin
      edge_src_r <= edge_src_nxt;
      window_r   <= window_nxt;
    end
  end

  // unpack the poll item
  assign levels = in_tdata[mked_pkg::FIELD_W-1:0];
  assign edges  = in_tdata[2*mked_pkg::FIELD_W-1:mked_pkg::FIELD_W];
  assign now    = in_tdata[2*mked_pkg::FIELD_W+mked_pkg::TIME_W-1:2*mked_pkg::FIELD_W];
  assign accept = in_tvalid && in_tready;

  // one lane per key; keys beyond the field width see all-zero inputs
  for (genvar k = 0; k < mked_pkg::KEYS; k++) begin : g_lane
    mked_pkg::mked_lane_cfg_t lcfg;
    logic                     lvl;
    logic                     edg;

    if (k < mked_pkg::FIELD_W) begin : g_in
      assign lcfg.edge_src = edge_src_r[k];
      assign lvl           = levels[k];
      assign edg           = edges[k];
    end else begin : g_pad
      assign lcfg.edge_src = 1'b0;
      assign lvl           = 1'b0;
      assign edg           = 1'b0;
    end
    assign lcfg.window = window_r;

    mked_lane u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .accept   (accept),
      .cfg      (lcfg),
      .level    (lvl),
      .edge_cap (edg),
      .now      (now),
      .fire     (fire[k])
    );
  end

  mked_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .fire      (fire),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule

@@ hdl/mked_lane.sv @@
// One key lane: held level, pending mark and start time of a single key.
// Depends on mked_pkg.
`timescale 1ns / 1ps

module mked_lane (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  mked_pkg::mked_lane_cfg_t     cfg,
  input  logic                         level,
  input  logic                         edge_cap,
  input  logic [mked_pkg::TIME_W-1:0]  now,
  output logic                         fire
);

  logic                        held_r, held_nxt;
  logic                        pending_r, pending_nxt;
  logic [mked_pkg::TIME_W-1:0] start_r, start_nxt;
  logic                        start;
  logic [mked_pkg::TIME_W-1:0] elapsed;
  logic                        pend_eff;

  always_comb begin
    start    = cfg.edge_src ? edge_cap : (level && !held_r);
    pend_eff = start || pending_r;
    // a fresh start has zero elapsed time
    elapsed  = start ? '0 : (now - start_r);
    fire     = pend_eff && (elapsed >= mked_pkg::TIME_W'(cfg.window));

    held_nxt    = held_r;
    pending_nxt = pending_r;
    start_nxt   = start_r;
    if (accept) begin
      held_nxt    = level;
      pending_nxt = pend_eff && !fire;
      if (start) begin
        start_nxt = now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r    <= 1'b0;
      pending_r <= 1'b0;
      start_r   <= '0;
    end else begin
      held_r    <= held_nxt;
      pending_r <= pending_nxt;
      start_r   <= start_nxt;
    end
  end

endmodule

@@ hdl/mked_merge.sv @@
// Merge stage: gathers lane fire bits into one result item and holds it
// in an output register backed by a skid entry. Depends on mked_pkg.
`timescale 1ns / 1ps

module mked_merge (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              accept,
  input  logic [mked_pkg::KEYS-1:0]         fire,
  output logic                              in_ready,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [mked_pkg::OUT_TDATA_W-1:0]  out_data
);

  logic [mked_pkg::FIELD_W-1:0] events;
  logic                         out_valid_r, out_valid_nxt;
  logic [mked_pkg::FIELD_W-1:0] out_data_r, out_data_nxt;
  logic                         skid_valid_r, skid_valid_nxt;
  logic [mked_pkg::FIELD_W-1:0] skid_data_r, skid_data_nxt;
  logic                         pop;

  // lanes past the field width never fire; field bits without a lane stay 0
  for (genvar j = 0; j < mked_pkg::FIELD_W; j++) begin : g_fold
    if (j < mked_pkg::KEYS) begin : g_on
      assign events[j] = fire[j];
    end else begin : g_off
      assign events[j] = 1'b0;
    end
  end

  assign pop      = out_valid_r && out_ready;
  assign in_ready = !skid_valid_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (pop) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (accept) begin
      if (!out_valid_r || pop) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = events;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = events;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = mked_pkg::OUT_TDATA_W'(out_data_r);

endmodule

@@ hdl/mked_checker.sv @@
// Port-level checker for the multi-key edge debouncer, bound to the top
// level. Depends on mked_pkg and multi_key_edge_debouncer_top.
`timescale 1ns / 1ps

module mked_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [mked_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  // no result survives reset
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // a new result only follows an accepted item
  a_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready))
    else $error("result without an item");

  // back-pressure only while a result is waiting
  a_bp: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with empty output");

endmodule

bind multi_key_edge_debouncer_top mked_checker u_mked_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ tb/testbench.sv @@
// Testbench for multi_key_edge_debouncer_top: streams poll items with random
// gaps and back-pressure, predicts each key-event result and checks it.
// Depends on mked_pkg and the debouncer RTL.
`timescale 1ns / 1ps

module testbench;
  import mked_pkg::*;

  // Register indexes outside the map; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  localparam int STALL_PCT    = 21;  // idle cycles per hundred, both sides
  localparam int MAX_REPORTS  = 10;
  localparam int DRAIN_CYCLES = 8;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata  = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  always #5 clk = ~clk;

  multi_key_edge_debouncer_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Predictor copy of the debouncer: configuration and per-key state.
  logic [FIELD_W-1:0] edge_src_mask;
  logic [WIN_W-1:0]   window_ticks;
  logic [FIELD_W-1:0] key_held;
  logic [FIELD_W-1:0] key_pending;
  logic [TIME_W-1:0]  key_start_ms [KEYS];

  logic [FIELD_W-1:0] expected_events [$];
  int                 mismatches = 0;
  bit                 stall_enable = 1'b1;

  // Stimulus state carried across phases: the running timestamp and levels.
  logic [TIME_W-1:0]  poll_ms    = 32'd1000;
  logic [FIELD_W-1:0] key_levels = '0;

  function automatic void clear_debouncer();
    edge_src_mask = EDGE_SRC_RST;
    window_ticks  = WINDOW_RST;
    key_held      = '0;
    key_pending   = '0;
    for (int k = 0; k < KEYS; k++) key_start_ms[k] = '0;
  endfunction

  // One poll: find each key's start, then fire keys whose window has run out.
  function automatic logic [FIELD_W-1:0] debounce_poll(
      input logic [FIELD_W-1:0] levels, input logic [FIELD_W-1:0] edges,
      input logic [TIME_W-1:0] now_ms);
    logic [FIELD_W-1:0] events;
    logic               restart;
    logic [TIME_W-1:0]  elapsed;
    events = '0;
    // keys past the field width see no input and never fire
    for (int k = 0; k < KEYS && k < FIELD_W; k++) begin
      restart = edge_src_mask[k] ? edges[k] : (levels[k] && !key_held[k]);
      key_held[k] = levels[k];
      if (restart) begin
        key_start_ms[k] = now_ms;
        key_pending[k]  = 1'b1;
      end
      elapsed = now_ms - key_start_ms[k];  // wraps modulo 2^32
      if (key_pending[k] && elapsed >= TIME_W'(window_ticks)) begin
        key_pending[k] = 1'b0;
        events[k]      = 1'b1;
      end
    end
    return events;
  endfunction

  task automatic flag_mismatch(input string what, input logic [FIELD_W-1:0] want,
                               input logic [OUT_TDATA_W-1:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t ns: %s: expected key_events %b, got tdata %b", $time, what, want, got);
  endtask

  // Sends one poll item, with a random gap first, and records its expected
  // result once the item has been taken.
  task automatic send_poll(input logic [FIELD_W-1:0] levels,
                           input logic [FIELD_W-1:0] edges,
                           input logic [TIME_W-1:0] now_ms);
    while (stall_enable && $urandom_range(99) < STALL_PCT) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'({now_ms, edges, levels});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_events.push_back(debounce_poll(levels, edges, now_ms));
  endtask

  // Drops in_tvalid so the last item is not taken twice.
  task automatic end_burst();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  // Register write, made only once every poll in flight has come back.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] value);
    end_burst();
    wait (expected_events.size() == 0);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (index)
      REG_EDGE_SRC: edge_src_mask = value[FIELD_W-1:0];
      REG_WINDOW:   window_ticks  = value[WIN_W-1:0];
      default: ;  // unmapped index, ignored
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Result checker: every taken result is matched against the oldest
  // expectation; padding bits above key_events must read zero.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_events.size() == 0)
        flag_mismatch("result with nothing outstanding", '0, out_tdata);
      else if (out_tdata !== OUT_TDATA_W'(expected_events[0]))
        flag_mismatch("key_events wrong", expected_events.pop_front(), out_tdata);
      else
        void'(expected_events.pop_front());
    end
  end

  // Receiver back-pressure.
  always @(negedge clk)
    out_tready <= !stall_enable || ($urandom_range(99) >= STALL_PCT);

  // Defaults after reset: edge-sourced keys, window of 20 ticks.
  task automatic test_reset_defaults();
    send_poll(5'b00000, 5'b00001, 32'd100);   // key 0 starts
    send_poll(5'b00000, 5'b00000, 32'd109);
    send_poll(5'b00000, 5'b00001, 32'd110);   // restart while pending
    send_poll(5'b00000, 5'b00000, 32'd125);   // old window would have fired
    send_poll(5'b00000, 5'b00000, 32'd130);   // fires now
    // levels alone must not start edge-sourced keys
    send_poll(5'b11111, 5'b00000, 32'd200);
    send_poll(5'b00000, 5'b00000, 32'd300);
    // all keys start just before the timestamp wraps, fire just after it
    send_poll(5'b11111, 5'b11111, 32'hffff_ffff);
    send_poll(5'b00000, 5'b00000, 32'h0000_0013);
  endtask

  // Polled keys with a zero window: start and event on the same poll.
  task automatic test_polled_zero_window();
    write_reg(REG_EDGE_SRC, 16'h0000);
    write_reg(REG_WINDOW, 16'h0000);
    send_poll(5'b00000, 5'b11111, 32'd400);   // edges ignored when polled
    send_poll(5'b10101, 5'b00000, 32'd401);
    send_poll(5'b11111, 5'b00000, 32'd402);   // only the new rises fire
    send_poll(5'b11111, 5'b11111, 32'd403);   // held, no rise
    send_poll(5'b00000, 5'b00000, 32'd404);
  endtask

  // Writes to unmapped indexes leave both registers alone.
  task automatic test_spare_indexes();
    write_reg(REG_SPARE_2, 16'hffff);
    write_reg(REG_SPARE_3, 16'haaaa);
    send_poll(5'b00001, 5'b00000, 32'd500);
  endtask

  // Widest window, mixed key sources; upper data bits of the mask write set.
  task automatic test_widest_window();
    write_reg(REG_EDGE_SRC, 16'hffea);
    write_reg(REG_WINDOW, 16'hffff);
    send_poll(5'b00101, 5'b01010, 32'd1000);
    send_poll(5'b00000, 5'b00000, 32'd1000 + 32'd65534);
    send_poll(5'b00000, 5'b00000, 32'd1000 + 32'd65535);
    poll_ms = 32'd1000 + 32'd65535;
  endtask

  // Random polls: the timestamp mostly creeps or jumps by about one window,
  // so keys go pending and fire often; now and then it leaps anywhere.
  task automatic run_random_polls(input int count);
    logic [FIELD_W-1:0] edges;
    logic [TIME_W-1:0]  step;
    int                 pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 20)      step = '0;
      else if (pick < 60) step = $urandom_range(0, window_ticks / 4 + 1);
      else if (pick < 88) step = TIME_W'(window_ticks) + $urandom_range(0, 2) - 1;
      else if (pick < 95) step = $urandom_range(0, 3 * window_ticks + 3);
      else                step = $urandom();
      poll_ms += step;
      if ($urandom_range(3) == 0) key_levels = FIELD_W'($urandom());
      else key_levels ^= FIELD_W'(1 << $urandom_range(FIELD_W - 1));
      edges = ($urandom_range(4) == 0) ? FIELD_W'($urandom())
                                       : FIELD_W'($urandom() & $urandom());
      send_poll(key_levels, edges, poll_ms);
    end
  endtask

  task automatic test_random_settings();
    write_reg(REG_EDGE_SRC, 16'($urandom()));
    write_reg(REG_WINDOW, 16'($urandom_range(1, 40)));
    run_random_polls(100);
    // polled keys, short window, timestamp about to wrap
    write_reg(REG_EDGE_SRC, 16'h0000);
    write_reg(REG_WINDOW, 16'd3);
    poll_ms = 32'hffff_ff00;
    run_random_polls(100);
    write_reg(REG_EDGE_SRC, 16'h001f);
    write_reg(REG_WINDOW, 16'hffff);
    run_random_polls(100);
    write_reg(REG_EDGE_SRC, 16'($urandom()));
    write_reg(REG_WINDOW, 16'h0000);
    run_random_polls(100);
    write_reg(REG_EDGE_SRC, 16'($urandom()));
    write_reg(REG_WINDOW, 16'($urandom()));
    run_random_polls(100);
  endtask

  // Back-to-back items with both sides always ready.
  task automatic test_full_rate();
    write_reg(REG_EDGE_SRC, 16'($urandom()));
    write_reg(REG_WINDOW, WINDOW_RST);
    stall_enable = 1'b0;
    run_random_polls(200);
    end_burst();
    wait (expected_events.size() == 0);
    stall_enable = 1'b1;
  endtask

  initial begin
    clear_debouncer();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_polled_zero_window();
    test_spare_indexes();
    test_widest_window();
    test_random_settings();
    test_full_rate();

    end_burst();
    wait (expected_events.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/mked_pkg.sv
hdl/mked_lane.sv
hdl/mked_merge.sv
hdl/multi_key_edge_debouncer_top.sv
hdl/mked_checker.sv
tb/testbench.sv
